### rtl/dcbq_pkg.sv
// Package with shared constants and types of the DC-blocking biquad high-pass filter.
`timescale 1ns / 1ps

package dcbq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;
    localparam int COEF_BITS          = 24;
    localparam int REG_INDEX_W        = 3;
    localparam int MODE_W             = 2;

    localparam logic [REG_INDEX_W-1:0] REG_HP_B0       = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_HP_B1       = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_HP_B2       = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_HP_A1       = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_HP_A2       = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_DC_GAIN     = 3'd5;
    localparam logic [REG_INDEX_W-1:0] REG_DC_FEEDBACK = 3'd6;
    localparam logic [REG_INDEX_W-1:0] REG_MODE        = 3'd7;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic neg;
    } dcbq_mac_ctrl_t;

endpackage

### rtl/dcbq_if.sv
// Stream interfaces for the input items and the result items of the filter.
`timescale 1ns / 1ps

interface dcbq_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output kind, output sample_in, input ready);
    modport sink   (input valid, input kind, input sample_in, output ready);
endinterface

interface dcbq_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### rtl/dcbq_mac.sv
// Shared multiply-accumulate unit with rounding, scaling and saturation.
`timescale 1ns / 1ps

module dcbq_mac #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dcbq_pkg::dcbq_mac_ctrl_t       ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] opa,
    input  dcbq_pkg::coef_t                coef,
    output logic signed [SAMPLE_WIDTH-1:0] q,
    output logic                           q_sat
);
    import dcbq_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else if (ctrl.mul_en)
        begin
            prod_reg <= opa * coef;
            neg_reg  <= ctrl.neg;
        end
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= RND;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    assign shifted = acc_reg >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            q     = SAT_HI[SAMPLE_WIDTH-1:0];
            q_sat = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            q     = SAT_LO[SAMPLE_WIDTH-1:0];
            q_sat = 1'b1;
        end
        else
        begin
            q     = shifted[SAMPLE_WIDTH-1:0];
            q_sat = 1'b0;
        end
    end

endmodule

### rtl/dc_block_biquad_highpass.sv
// Top level of the DC-blocking biquad high-pass filter with its sequencer and registers.
//
// Channel    Dir  Handshake        Payload
// in_ch      in   valid / ready    kind, sample_in
// out_ch     out  valid / ready    sample_out, saturated
// cfg        in   cfg_wr_en only   cfg_index, cfg_data
//
// A filtered item passes the accepting state, then a multiply state and an accumulate state
// for each of the eight products with the DC stage on, or five with it off, in the one
// shared multiplier, then one scaling state per stage and a final state that loads the
// output register and waits there while that register is still full.
// A pass-through item goes straight to that final state, and a preset item gives no result.
// Reset clears the coefficient registers, the delay elements and the handshake state, and sets the mode to MODE_RESET.
// A result waiting in the output register does not stop the next item from being
// accepted; only a new result that finds it still full waits.
`timescale 1ns / 1ps

module dc_block_biquad_highpass #(
    parameter int SAMPLE_WIDTH   = dcbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = dcbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dcbq_in_if.sink                             in_ch,
    dcbq_out_if.source                          out_ch,
    input  logic                                cfg_wr_en,
    input  logic [dcbq_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  logic [dcbq_pkg::COEF_BITS-1:0]      cfg_data
);
    import dcbq_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL      = 3'd1;
    localparam logic [2:0] ST_ACC      = 3'd2;
    localparam logic [2:0] ST_DC_SCALE = 3'd3;
    localparam logic [2:0] ST_HP_SCALE = 3'd4;
    localparam logic [2:0] ST_FIN      = 3'd5;

    localparam logic [2:0] TERM_DC_X    = 3'd0;
    localparam logic [2:0] TERM_DC_X1   = 3'd1;
    localparam logic [2:0] TERM_DC_Y1   = 3'd2;
    localparam logic [2:0] TERM_HP_X    = 3'd3;
    localparam logic [2:0] TERM_HP_X1   = 3'd4;
    localparam logic [2:0] TERM_HP_X2   = 3'd5;
    localparam logic [2:0] TERM_HP_Y1   = 3'd6;
    localparam logic [2:0] TERM_HP_Y2   = 3'd7;

    coef_t hp_b0_reg, hp_b1_reg, hp_b2_reg, hp_a1_reg, hp_a2_reg;
    coef_t dc_gain_reg, dc_feedback_reg;
    logic [MODE_W-1:0] mode_reg;

    logic [2:0] state_reg, state_next;
    logic [2:0] term_reg, term_next;

    logic signed [SAMPLE_WIDTH-1:0] x_reg, v_reg, res_reg;
    logic                           res_sat_reg;
    logic signed [SAMPLE_WIDTH-1:0] dc_prev_in_reg, dc_prev_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_hist0_reg, in_hist1_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_hist0_reg, out_hist1_reg;

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_sat_reg;

    logic                           in_take;
    logic                           out_load;
    dcbq_mac_ctrl_t                 mac_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] mac_opa;
    coef_t                          mac_coef;
    logic                           mac_neg;
    logic signed [SAMPLE_WIDTH-1:0] mac_q;
    logic                           mac_q_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_b0_reg       <= '0;
            hp_b1_reg       <= '0;
            hp_b2_reg       <= '0;
            hp_a1_reg       <= '0;
            hp_a2_reg       <= '0;
            dc_gain_reg     <= '0;
            dc_feedback_reg <= '0;
            mode_reg        <= MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HP_B0:       hp_b0_reg       <= cfg_data;
                REG_HP_B1:       hp_b1_reg       <= cfg_data;
                REG_HP_B2:       hp_b2_reg       <= cfg_data;
                REG_HP_A1:       hp_a1_reg       <= cfg_data;
                REG_HP_A2:       hp_a2_reg       <= cfg_data;
                REG_DC_GAIN:     dc_gain_reg     <= cfg_data;
                REG_DC_FEEDBACK: dc_feedback_reg <= cfg_data;
                REG_MODE:        mode_reg        <= cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        case (term_reg)
            TERM_DC_X:  begin mac_opa = x_reg;           mac_coef = dc_gain_reg;     mac_neg = 1'b0; end
            TERM_DC_X1: begin mac_opa = dc_prev_in_reg;  mac_coef = dc_gain_reg;     mac_neg = 1'b1; end
            TERM_DC_Y1: begin mac_opa = dc_prev_out_reg; mac_coef = dc_feedback_reg; mac_neg = 1'b1; end
            TERM_HP_X:  begin mac_opa = v_reg;           mac_coef = hp_b0_reg;       mac_neg = 1'b0; end
            TERM_HP_X1: begin mac_opa = in_hist0_reg;    mac_coef = hp_b1_reg;       mac_neg = 1'b0; end
            TERM_HP_X2: begin mac_opa = in_hist1_reg;    mac_coef = hp_b2_reg;       mac_neg = 1'b0; end
            TERM_HP_Y1: begin mac_opa = out_hist0_reg;   mac_coef = hp_a1_reg;       mac_neg = 1'b1; end
            TERM_HP_Y2: begin mac_opa = out_hist1_reg;   mac_coef = hp_a2_reg;       mac_neg = 1'b1; end
            default:    begin mac_opa = x_reg;           mac_coef = dc_gain_reg;     mac_neg = 1'b0; end
        endcase
    end

    always_comb
    begin
        mac_ctrl.clear  = (in_take && !in_ch.kind && mode_reg[0]) || (state_reg == ST_DC_SCALE);
        mac_ctrl.mul_en = (state_reg == ST_MUL);
        mac_ctrl.acc_en = (state_reg == ST_ACC);
        mac_ctrl.neg    = mac_neg;
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && !in_ch.kind)
                begin
                    if (!mode_reg[0])
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        term_next  = mode_reg[1] ? TERM_DC_X : TERM_HP_X;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (term_reg == TERM_DC_Y1)
                begin
                    state_next = ST_DC_SCALE;
                end
                else if (term_reg == TERM_HP_Y2)
                begin
                    state_next = ST_HP_SCALE;
                end
                else
                begin
                    state_next = ST_MUL;
                    term_next  = term_reg + 3'd1;
                end
            end
            ST_DC_SCALE:
            begin
                state_next = ST_MUL;
                term_next  = TERM_HP_X;
            end
            ST_HP_SCALE:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_DC_X;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_prev_in_reg  <= '0;
            dc_prev_out_reg <= '0;
            in_hist0_reg    <= '0;
            in_hist1_reg    <= '0;
            out_hist0_reg   <= '0;
            out_hist1_reg   <= '0;
        end
        else if (in_take && in_ch.kind)
        begin
            dc_prev_in_reg  <= in_ch.sample_in;
            dc_prev_out_reg <= in_ch.sample_in;
            in_hist0_reg    <= in_ch.sample_in;
            in_hist1_reg    <= in_ch.sample_in;
            out_hist0_reg   <= in_ch.sample_in;
            out_hist1_reg   <= in_ch.sample_in;
        end
        else if (state_reg == ST_DC_SCALE)
        begin
            dc_prev_in_reg  <= x_reg;
            dc_prev_out_reg <= mac_q;
        end
        else if (state_reg == ST_HP_SCALE)
        begin
            in_hist1_reg  <= in_hist0_reg;
            in_hist0_reg  <= v_reg;
            out_hist1_reg <= out_hist0_reg;
            out_hist0_reg <= mac_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && !in_ch.kind)
        begin
            x_reg       <= in_ch.sample_in;
            v_reg       <= in_ch.sample_in;
            res_reg     <= in_ch.sample_in;
            res_sat_reg <= 1'b0;
        end
        else if (state_reg == ST_DC_SCALE)
        begin
            v_reg       <= mac_q;
            res_sat_reg <= res_sat_reg | mac_q_sat;
        end
        else if (state_reg == ST_HP_SCALE)
        begin
            res_reg     <= mac_q;
            res_sat_reg <= res_sat_reg | mac_q_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= res_reg;
            out_sat_reg    <= res_sat_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.saturated  = out_sat_reg;

    dcbq_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .opa   (mac_opa),
        .coef  (mac_coef),
        .q     (mac_q),
        .q_sat (mac_q_sat)
    );

endmodule
